/* hdl/assert_macros.svh */
// assertion helpers, clocked on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PHLC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PHLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/phlc_pkg.sv */
package phlc_pkg;

    // command codes of the input word
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_HEIGHT = 2'd1;
    localparam logic [1:0] CMD_CROSS  = 2'd2;

    // register byte address
    localparam logic [2:0] REG_POINT_COUNT = 3'd0;

    localparam int FRAC_BITS = 16;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_HEIGHT,
        OP_CROSS,
        OP_NONE
    } op_t;

    typedef enum logic {
        AOP_MUL,
        AOP_DIV
    } aop_t;

    typedef struct packed {
        logic        start;
        aop_t        op;
    } arith_req_t;

    typedef struct packed {
        logic        idle;
        logic        done;
    } arith_rsp_t;

    typedef struct packed {
        logic        full;
        logic        empty;
    } q_status_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         index;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] slope;
        logic               direction;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] height;
        logic               inside_res;
        logic signed [31:0] cross_x;
        logic               found;
    } out_word_t;

endpackage

/* hdl/phlc_stream_if.sv */
interface phlc_stream_if #(parameter type word_t = phlc_pkg::in_word_t);
    logic  valid;
    logic  ready;
    word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* hdl/phlc_fifo.sv */
`include "assert_macros.svh"

module phlc_fifo #(
    parameter int WIDTH = 107,
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [WIDTH-1:0]     din,
    input  logic                 pop,
    output logic [WIDTH-1:0]     dout,
    output phlc_pkg::q_status_t  status
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (int'(p) == DEPTH - 1) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNTW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store[wr_ptr_reg] <= din;
    end

    assign dout         = store[rd_ptr_reg];
    assign status.full  = (int'(count_reg) == DEPTH);
    assign status.empty = (count_reg == '0);

    `PHLC_ASSERT_IMPL(a_no_overflow, push, int'(count_reg) < DEPTH, "push into full queue")
    `PHLC_ASSERT_IMPL(a_no_underflow, pop, count_reg != '0, "pop from empty queue")
    `PHLC_ASSERT_NEXT(a_push_fills, push, count_reg != '0, "queue empty after push")
endmodule

/* hdl/phlc_front.sv */
module phlc_front #(
    parameter int CW         = 32,
    parameter int MAX_POINTS = 256
) (
    phlc_stream_if.sink                in_ch,
    input  phlc_pkg::q_status_t        q_stat,
    output logic                       q_push,
    output logic [3*CW+10:0]           q_item
);
    phlc_pkg::op_t     op;
    logic [CW-1:0]     x_c;
    logic [CW-1:0]     y_c;
    logic [CW-1:0]     k_c;

    // decode the command; writes past the store become no-ops
    always_comb
    begin
        unique case (in_ch.payload.cmd)
            phlc_pkg::CMD_WRITE:
                op = (int'(in_ch.payload.index) < MAX_POINTS) ? phlc_pkg::OP_WRITE
                                                               : phlc_pkg::OP_NONE;
            phlc_pkg::CMD_HEIGHT: op = phlc_pkg::OP_HEIGHT;
            phlc_pkg::CMD_CROSS:  op = phlc_pkg::OP_CROSS;
            default:              op = phlc_pkg::OP_NONE;
        endcase
    end

    // coordinates carried at the internal width
    assign x_c = CW'($unsigned(in_ch.payload.coord_x));
    assign y_c = CW'($unsigned(in_ch.payload.coord_y));
    assign k_c = CW'($unsigned(in_ch.payload.slope));

    assign in_ch.ready = !q_stat.full;
    assign q_push      = in_ch.valid && !q_stat.full;
    assign q_item      = {op, in_ch.payload.index, x_c, y_c, k_c, in_ch.payload.direction};
endmodule

/* hdl/phlc_arith.sv */
module phlc_arith #(
    parameter int CW = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  phlc_pkg::arith_req_t        req,
    input  logic signed [3*CW+3:0]      opa,
    input  logic signed [3*CW+3:0]      opb,
    output phlc_pkg::arith_rsp_t        rsp,
    output logic signed [3*CW+3:0]      result
);
    localparam int W = 3 * CW + 4;
    localparam int CNTW = $clog2(W + 1);

    typedef enum logic [1:0] {
        A_IDLE,
        A_MUL,
        A_DIV
    } astate_t;

    astate_t          state_reg, state_next;
    logic [W-1:0]     acc_reg, acc_next;
    logic [W-1:0]     sh_reg, sh_next;
    logic [W-1:0]     mb_reg, mb_next;
    logic             neg_reg, neg_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [W-1:0]     res_reg, res_next;

    always_comb
    begin
        logic [W-1:0] acc_add;
        logic [W-1:0] rem_sh;
        logic         qbit;
        state_next = state_reg;
        acc_next   = acc_reg;
        sh_next    = sh_reg;
        mb_next    = mb_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        acc_add    = acc_reg + (mb_reg[0] ? sh_reg : '0);
        rem_sh     = {acc_reg[W-2:0], sh_reg[W-1]};
        qbit       = (rem_sh >= mb_reg);
        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    // work on magnitudes, sign applied at the end
                    sh_next    = opa[W-1] ? $unsigned(-opa) : $unsigned(opa);
                    mb_next    = opb[W-1] ? $unsigned(-opb) : $unsigned(opb);
                    neg_next   = opa[W-1] ^ opb[W-1];
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = (req.op == phlc_pkg::AOP_MUL) ? A_MUL : A_DIV;
                end
            end
            A_MUL:
            begin
                // shift-add over the narrow operand
                acc_next = acc_add;
                sh_next  = {sh_reg[W-2:0], 1'b0};
                mb_next  = {1'b0, mb_reg[W-1:1]};
                cnt_next = cnt_reg + CNTW'(1);
                if (int'(cnt_reg) == CW - 1)
                begin
                    res_next   = neg_reg ? (~acc_add + W'(1)) : acc_add;
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
            end
            A_DIV:
            begin
                // restoring division, one quotient bit per cycle
                acc_next = qbit ? (rem_sh - mb_reg) : rem_sh;
                sh_next  = {sh_reg[W-2:0], qbit};
                cnt_next = cnt_reg + CNTW'(1);
                if (int'(cnt_reg) == W - 1)
                begin
                    res_next   = neg_reg ? (~{sh_reg[W-2:0], qbit} + W'(1))
                                         : {sh_reg[W-2:0], qbit};
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
            end
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

    assign rsp.idle = (state_reg == A_IDLE);
    assign rsp.done = done_reg;
    assign result   = $signed(res_reg);
endmodule

/* hdl/phlc_back.sv */
`include "assert_macros.svh"

module phlc_back #(
    parameter int CW         = 32,
    parameter int MAX_POINTS = 256
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [3*CW+10:0]        q_item,
    input  phlc_pkg::q_status_t     q_stat,
    output logic                    q_pop,
    input  logic [8:0]              point_count,
    phlc_stream_if.source           out_ch
);
    localparam int W  = 3 * CW + 4;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam logic signed [W-1:0] HI_W = {{(W-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [W-1:0] LO_W = {{(W-CW+1){1'b1}}, {(CW-1){1'b0}}};
    localparam logic signed [W-1:0] ZERO_W = '0;

    typedef enum logic [4:0] {
        ST_IDLE, ST_GET0, ST_GETL,
        ST_HSCAN, ST_HA, ST_HCHK, ST_HMUL, ST_HMULW, ST_HDIV, ST_HDIVW,
        ST_XSCAN, ST_XSTART, ST_XSEG, ST_XA, ST_XB, ST_XCHK,
        ST_XM1, ST_XW1, ST_XM2, ST_XW2, ST_XNORM, ST_XRANGE,
        ST_XM3, ST_XW3, ST_XM4, ST_XW4, ST_XD, ST_XWD, ST_XNEXT
    } state_t;

    state_t                 state_reg, state_next;
    phlc_pkg::op_t          op_reg, op_next;
    logic signed [CW-1:0]   x_reg, x_next, y_reg, y_next, k_reg, k_next;
    logic                   dir_reg, dir_next;
    logic signed [CW-1:0]   xf_reg, xf_next, xl_reg, xl_next;
    logic signed [CW-1:0]   xa_reg, xa_next, ya_reg, ya_next;
    logic signed [CW-1:0]   xb_reg, xb_next, yb_reg, yb_next;
    logic [NW-1:0]          i_reg, i_next;
    logic signed [W-1:0]    d_reg, d_next, q_reg, q_next, p_reg, p_next;
    logic                   out_valid_reg, out_valid_next;
    phlc_pkg::out_word_t    out_reg, out_next;

    logic signed [CW-1:0]   mem_x [MAX_POINTS];
    logic signed [CW-1:0]   mem_y [MAX_POINTS];
    logic signed [CW-1:0]   rd_x_reg, rd_y_reg;
    logic [AW-1:0]          rd_addr;
    logic                   wr_en;

    phlc_pkg::arith_req_t   ar_req;
    phlc_pkg::arith_rsp_t   ar_rsp;
    logic signed [W-1:0]    ar_a, ar_b, ar_res;

    phlc_pkg::op_t          it_op;
    logic [7:0]             it_idx;
    logic signed [CW-1:0]   it_x, it_y, it_k;
    logic                   it_dir;

    logic [NW-1:0]          n_pts, n_m1, n_m2;
    logic [NW-1:0]          i_inc, i_dec;
    logic signed [W-1:0]    dx_w, dy_w, xd_w;

    assign it_op  = phlc_pkg::op_t'(q_item[3*CW+10 -: 2]);
    assign it_idx = q_item[3*CW+8 -: 8];
    assign it_x   = $signed(q_item[3*CW : 2*CW+1]);
    assign it_y   = $signed(q_item[2*CW : CW+1]);
    assign it_k   = $signed(q_item[CW : 1]);
    assign it_dir = q_item[0];

    // active breakpoint count, clamped to the range 2 to MAX_POINTS
    always_comb
    begin
        int pc;
        pc = int'(point_count);
        if (pc < 2)
            pc = 2;
        if (pc > MAX_POINTS)
            pc = MAX_POINTS;
        n_pts = NW'(pc);
    end

    assign n_m1  = n_pts - NW'(1);
    assign n_m2  = n_pts - NW'(2);
    assign i_inc = i_reg + NW'(1);
    assign i_dec = i_reg - NW'(1);
    assign dx_w  = W'(xb_reg) - W'(xa_reg);
    assign dy_w  = W'(yb_reg) - W'(ya_reg);
    assign xd_w  = W'(x_reg) - W'(xa_reg);

    function automatic logic signed [CW-1:0] sat_c(input logic signed [W-1:0] v);
        if (v > HI_W)
            sat_c = HI_W[CW-1:0];
        else if (v < LO_W)
            sat_c = LO_W[CW-1:0];
        else
            sat_c = v[CW-1:0];
    endfunction

    always_comb
    begin
        logic signed [CW-1:0] h;
        logic signed [W-1:0]  qv;
        state_next     = state_reg;
        op_next        = op_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        k_next         = k_reg;
        dir_next       = dir_reg;
        xf_next        = xf_reg;
        xl_next        = xl_reg;
        xa_next        = xa_reg;
        ya_next        = ya_reg;
        xb_next        = xb_reg;
        yb_next        = yb_reg;
        i_next         = i_reg;
        d_next         = d_reg;
        q_next         = q_reg;
        p_next         = p_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_next       = out_reg;
        rd_addr        = '0;
        wr_en          = 1'b0;
        q_pop          = 1'b0;
        ar_req.start   = 1'b0;
        ar_req.op      = phlc_pkg::AOP_MUL;
        ar_a           = p_reg;
        ar_b           = dx_w;
        h              = '0;
        qv             = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty && !out_valid_reg)
                begin
                    q_pop    = 1'b1;
                    op_next  = it_op;
                    x_next   = it_x;
                    y_next   = it_y;
                    k_next   = it_k;
                    dir_next = it_dir;
                    out_next = '0;
                    unique case (it_op)
                        phlc_pkg::OP_WRITE:
                        begin
                            wr_en          = 1'b1;
                            out_valid_next = 1'b1;
                        end
                        phlc_pkg::OP_HEIGHT, phlc_pkg::OP_CROSS:
                            state_next = ST_GET0;
                        default: out_valid_next = 1'b1;
                    endcase
                end
            end
            ST_GET0:
            begin
                xf_next    = rd_x_reg;
                rd_addr    = n_m1[AW-1:0];
                state_next = ST_GETL;
            end
            ST_GETL:
            begin
                xl_next = rd_x_reg;
                if (op_reg == phlc_pkg::OP_HEIGHT)
                begin
                    i_next     = NW'(1);
                    rd_addr    = AW'(1);
                    state_next = ST_HSCAN;
                end
                else if (x_reg < xf_reg)
                begin
                    i_next     = '0;
                    state_next = ST_XSTART;
                end
                else if (x_reg > rd_x_reg)
                begin
                    i_next     = n_pts;
                    state_next = ST_XSTART;
                end
                else
                begin
                    i_next     = '0;
                    rd_addr    = '0;
                    state_next = ST_XSCAN;
                end
            end

            // height query
            ST_HSCAN:
            begin
                if (i_reg < n_m1 && x_reg > rd_x_reg)
                begin
                    i_next  = i_inc;
                    rd_addr = i_inc[AW-1:0];
                end
                else
                begin
                    xb_next    = rd_x_reg;
                    yb_next    = rd_y_reg;
                    rd_addr    = i_dec[AW-1:0];
                    state_next = ST_HA;
                end
            end
            ST_HA:
            begin
                xa_next    = rd_x_reg;
                ya_next    = rd_y_reg;
                state_next = ST_HCHK;
            end
            ST_HCHK:
            begin
                if (dx_w == '0)
                begin
                    h                  = ya_reg;
                    out_next.height    = 32'(h);
                    out_next.inside_res = (x_reg >= xf_reg) && (x_reg <= xl_reg) && (y_reg <= h);
                    out_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
                else
                    state_next = ST_HMUL;
            end
            ST_HMUL:
            begin
                ar_req.start = 1'b1;
                ar_a         = dy_w;
                ar_b         = xd_w;
                state_next   = ST_HMULW;
            end
            ST_HMULW:
            begin
                if (ar_rsp.done)
                begin
                    p_next     = ar_res;
                    state_next = ST_HDIV;
                end
            end
            ST_HDIV:
            begin
                ar_req.start = 1'b1;
                ar_req.op    = phlc_pkg::AOP_DIV;
                ar_a         = p_reg;
                ar_b         = dx_w;
                state_next   = ST_HDIVW;
            end
            ST_HDIVW:
            begin
                if (ar_rsp.done)
                begin
                    h                   = sat_c(W'(ya_reg) + ar_res);
                    out_next.height     = 32'(h);
                    out_next.inside_res = (x_reg >= xf_reg) && (x_reg <= xl_reg) && (y_reg <= h);
                    out_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end

            // crossing query
            ST_XSCAN:
            begin
                if (i_reg < n_m1 && rd_x_reg < x_reg)
                begin
                    i_next  = i_inc;
                    rd_addr = i_inc[AW-1:0];
                end
                else
                    state_next = ST_XSTART;
            end
            ST_XSTART:
            begin
                // i holds the start breakpoint; turn it into the first segment
                if (dir_reg)
                begin
                    if (i_reg == n_pts)
                    begin
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = (i_reg != '0) ? i_dec : '0;
                        state_next = ST_XSEG;
                    end
                end
                else if (i_reg == '0)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    i_next     = (i_dec > n_m2) ? n_m2 : i_dec;
                    state_next = ST_XSEG;
                end
            end
            ST_XSEG:
            begin
                rd_addr    = i_reg[AW-1:0];
                state_next = ST_XA;
            end
            ST_XA:
            begin
                xa_next    = rd_x_reg;
                ya_next    = rd_y_reg;
                rd_addr    = i_inc[AW-1:0];
                state_next = ST_XB;
            end
            ST_XB:
            begin
                xb_next    = rd_x_reg;
                yb_next    = rd_y_reg;
                state_next = ST_XCHK;
            end
            ST_XCHK:
                state_next = (dx_w > ZERO_W) ? ST_XM1 : ST_XNEXT;
            ST_XM1:
            begin
                ar_req.start = 1'b1;
                ar_a         = W'(k_reg);
                ar_b         = dx_w;
                state_next   = ST_XW1;
            end
            ST_XW1:
            begin
                if (ar_rsp.done)
                begin
                    d_next     = ar_res - (dy_w <<< phlc_pkg::FRAC_BITS);
                    state_next = ST_XM2;
                end
            end
            ST_XM2:
            begin
                ar_req.start = 1'b1;
                ar_a         = W'(k_reg);
                ar_b         = -xd_w;
                state_next   = ST_XW2;
            end
            ST_XW2:
            begin
                if (ar_rsp.done)
                begin
                    qv         = (W'(ya_reg) - W'(y_reg)) <<< phlc_pkg::FRAC_BITS;
                    q_next     = qv - ar_res;
                    state_next = ST_XNORM;
                end
            end
            ST_XNORM:
            begin
                // parallel segment: skip; otherwise make the denominator positive
                if (d_reg == '0)
                    state_next = ST_XNEXT;
                else
                begin
                    if (d_reg < ZERO_W)
                    begin
                        d_next = -d_reg;
                        q_next = -q_reg;
                    end
                    state_next = ST_XRANGE;
                end
            end
            ST_XRANGE:
                state_next = (q_reg > ZERO_W && q_reg < d_reg) ? ST_XM3 : ST_XNEXT;
            ST_XM3:
            begin
                ar_req.start = 1'b1;
                ar_a         = q_reg;
                ar_b         = dx_w;
                state_next   = ST_XW3;
            end
            ST_XW3:
            begin
                if (ar_rsp.done)
                begin
                    p_next     = ar_res;
                    state_next = ST_XM4;
                end
            end
            ST_XM4:
            begin
                ar_req.start = 1'b1;
                ar_a         = d_reg;
                ar_b         = xd_w;
                state_next   = ST_XW4;
            end
            ST_XW4:
            begin
                // crossing must lie strictly beyond the origin
                if (ar_rsp.done)
                begin
                    if (dir_reg ? (p_reg > ar_res) : (p_reg < ar_res))
                        state_next = ST_XD;
                    else
                        state_next = ST_XNEXT;
                end
            end
            ST_XD:
            begin
                ar_req.start = 1'b1;
                ar_req.op    = phlc_pkg::AOP_DIV;
                ar_a         = p_reg;
                ar_b         = d_reg;
                state_next   = ST_XWD;
            end
            ST_XWD:
            begin
                if (ar_rsp.done)
                begin
                    out_next.cross_x = 32'(sat_c(W'(xa_reg) + ar_res));
                    out_next.found   = 1'b1;
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_XNEXT:
            begin
                if (dir_reg ? (i_reg == n_m2) : (i_reg == '0))
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    i_next     = dir_reg ? i_inc : i_dec;
                    state_next = ST_XSEG;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        k_reg   <= k_next;
        dir_reg <= dir_next;
        xf_reg  <= xf_next;
        xl_reg  <= xl_next;
        xa_reg  <= xa_next;
        ya_reg  <= ya_next;
        xb_reg  <= xb_next;
        yb_reg  <= yb_next;
        i_reg   <= i_next;
        d_reg   <= d_next;
        q_reg   <= q_next;
        p_reg   <= p_next;
        out_reg <= out_next;
    end

    // breakpoint store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[AW'(it_idx)] <= it_x;
            mem_y[AW'(it_idx)] <= it_y;
        end
        rd_x_reg <= mem_x[rd_addr];
        rd_y_reg <= mem_y[rd_addr];
    end

    phlc_arith #(.CW(CW)) u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (ar_req),
        .opa    (ar_a),
        .opb    (ar_b),
        .rsp    (ar_rsp),
        .result (ar_res)
    );

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_reg;

    `PHLC_ASSERT_IMPL(a_start_idle, ar_req.start, ar_rsp.idle, "arith unit started while busy")
    `PHLC_ASSERT_IMPL(a_pop_free, q_pop, !out_valid_reg && !q_stat.empty, "pop while result pending")
    `PHLC_ASSERT_IMPL(a_done_waited, ar_rsp.done,
        state_reg == ST_HMULW || state_reg == ST_HDIVW || state_reg == ST_XW1 ||
        state_reg == ST_XW2 || state_reg == ST_XW3 || state_reg == ST_XW4 ||
        state_reg == ST_XWD, "arith result with nobody waiting")
endmodule

/* hdl/profile_height_and_line_crossing_core.sv */
// from input acceptance: a write or unused command goes straight to the result word;
//   height query: breakpoint scan, then multiply and divide unless the segment has zero width
// crossing query: breakpoint scan, then per segment up to four multiplies,
//   and a divide for the crossing found; one query at a time in the back end
// throughput set by the shared bit-serial multiply/divide unit; two words queue ahead
// reset: rst_n asynchronous active low, point_count back to 2, breakpoints undefined until written
module profile_height_and_line_crossing_core #(
    parameter int MAX_POINTS  = 256,
    parameter int COORD_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    // register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // word channels
    phlc_stream_if.sink   in_ch,
    phlc_stream_if.source out_ch
);
    localparam int QW = 3 * COORD_WIDTH + 11;

    // point count register; the user keeps it stable while the core is idle, the block does not enforce it
    logic [8:0]          point_count_reg;
    // queue between the decode front and the execution back end
    logic                q_push;
    logic                q_pop;
    logic [QW-1:0]       q_in;
    logic [QW-1:0]       q_out;
    phlc_pkg::q_status_t q_stat;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            point_count_reg <= 9'd2;
        else if (psel && penable && pwrite && paddr == phlc_pkg::REG_POINT_COUNT)
            point_count_reg <= pwdata[8:0];
    end

    // reads of unmapped addresses return zero
    assign prdata = (paddr == phlc_pkg::REG_POINT_COUNT) ? {23'd0, point_count_reg} : 32'd0;

    // front: takes input words, decodes the command
    phlc_front #(.CW(COORD_WIDTH), .MAX_POINTS(MAX_POINTS)) u_front (
        .in_ch  (in_ch),
        .q_stat (q_stat),
        .q_push (q_push),
        .q_item (q_in)
    );

    // short queue lets the front keep accepting while a query runs
    phlc_fifo #(.WIDTH(QW), .DEPTH(2)) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .din    (q_in),
        .pop    (q_pop),
        .dout   (q_out),
        .status (q_stat)
    );

    // back: breakpoint store, sequencer, arith unit and result register
    phlc_back #(.CW(COORD_WIDTH), .MAX_POINTS(MAX_POINTS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_item      (q_out),
        .q_stat      (q_stat),
        .q_pop       (q_pop),
        .point_count (point_count_reg),
        .out_ch      (out_ch)
    );
endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int NPTS      = 256;
    localparam int WIDE      = 160;
    localparam int IDLE_MAX  = 400000;
    localparam int DRAIN_CYC = 120;

    typedef logic signed [WIDE-1:0] wide_t;

    // one row of the directed table: input word, whether the answer is typed in, and the answer
    typedef struct {
        phlc_pkg::in_word_t  w;
        bit                  typed;
        phlc_pkg::out_word_t ans;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    phlc_stream_if #(.word_t(phlc_pkg::in_word_t))  in_if ();
    phlc_stream_if #(.word_t(phlc_pkg::out_word_t)) out_if ();

    profile_height_and_line_crossing_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_if.sink),
        .out_ch  (out_if.source)
    );

    // shadow copy of the profile and the point count
    logic signed [31:0] prof_x [NPTS];
    logic signed [31:0] prof_y [NPTS];
    bit                 loaded [NPTS];
    logic [8:0]         pc_shadow;

    // answers still owed by the block, oldest first
    phlc_pkg::out_word_t answer_q [$];

    int errors;
    int idle_cycles;
    int rx_stall;
    bit rx_burst;
    bit tx_burst;
    int n_writes;
    int n_height;
    int n_cross;
    int n_found;
    int n_unused;
    int n_words_out;

    // clock, 4 ns period
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic int active_points();
        if (pc_shadow < 2)
            return 2;
        if (pc_shadow > NPTS)
            return NPTS;
        return int'(pc_shadow);
    endfunction

    // clamp a wide value to the signed 32-bit range
    function automatic logic signed [31:0] clamp32(wide_t v);
        wide_t hi;
        wide_t lo;
        hi = 32'sh7fffffff;
        lo = -hi - 1;
        if (v > hi)
            return 32'sh7fffffff;
        if (v < lo)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // linear interpolation on the segment holding x, extrapolation at the ends
    function automatic logic signed [31:0] surface_height(logic signed [31:0] x, int n);
        int    i;
        wide_t xa;
        wide_t ya;
        wide_t dx;
        wide_t dy;
        wide_t px;
        i = 1;
        while (i < n - 1 && x > prof_x[i])
            i++;
        xa = prof_x[i-1];
        ya = prof_y[i-1];
        px = x;
        dx = prof_x[i];
        dx = dx - xa;
        dy = prof_y[i];
        dy = dy - ya;
        if (dx == 0)
            return ya[31:0];
        // signed division truncates toward zero
        return clamp32(ya + (dy * (px - xa)) / dx);
    endfunction

    // first strict crossing of the line with the profile, walking from the origin
    function automatic bit line_crossing(logic signed [31:0] k, logic signed [31:0] x0,
                                         logic signed [31:0] y0, bit right, int n,
                                         output logic signed [31:0] xr);
        int    s;
        int    seg;
        int    last;
        wide_t ws;
        wide_t wk;
        wide_t wx0;
        wide_t wy0;
        wide_t xa;
        wide_t ya;
        wide_t dx;
        wide_t dy;
        wide_t d;
        wide_t q;
        wide_t p;
        wide_t r;
        bit    beyond;
        ws  = wide_t'(1) <<< phlc_pkg::FRAC_BITS;
        wk  = k;
        wx0 = x0;
        wy0 = y0;
        xr  = '0;
        if (x0 < prof_x[0])
            s = 0;
        else if (x0 > prof_x[n-1])
            s = n;
        else
        begin
            s = 0;
            while (s < n - 1 && prof_x[s] < x0)
                s++;
        end
        if (right)
        begin
            seg  = (s > 0) ? s - 1 : 0;
            last = n - 2;
        end
        else
        begin
            if (s == 0)
                return 1'b0;
            seg  = (s - 1 > n - 2) ? n - 2 : s - 1;
            last = 0;
        end
        while (right ? seg <= last : seg >= last)
        begin
            xa = prof_x[seg];
            ya = prof_y[seg];
            dx = prof_x[seg+1];
            dx = dx - xa;
            dy = prof_y[seg+1];
            dy = dy - ya;
            if (dx > 0)
            begin
                d = wk * dx - ws * dy;
                q = ws * (ya - wy0) - wk * (xa - wx0);
                // parallel segments have d zero
                if (d != 0)
                begin
                    if (d < 0)
                    begin
                        d = -d;
                        q = -q;
                    end
                    if (q > 0 && q < d)
                    begin
                        p = dx * q;
                        r = (wx0 - xa) * d;
                        beyond = right ? (p > r) : (p < r);
                        if (beyond)
                        begin
                            xr = clamp32(xa + p / d);
                            return 1'b1;
                        end
                    end
                end
            end
            seg += right ? 1 : -1;
        end
        return 1'b0;
    endfunction

    // answer for one accepted word; updates the shadow profile on writes
    function automatic phlc_pkg::out_word_t profile_answer(phlc_pkg::in_word_t w);
        phlc_pkg::out_word_t o;
        int                  n;
        logic signed [31:0]  h;
        logic signed [31:0]  xr;
        o = '0;
        n = active_points();
        case (w.cmd)
            phlc_pkg::CMD_WRITE:
            begin
                prof_x[w.index] = w.coord_x;
                prof_y[w.index] = w.coord_y;
                loaded[w.index] = 1'b1;
            end
            phlc_pkg::CMD_HEIGHT:
            begin
                h = surface_height(w.coord_x, n);
                o.height = h;
                o.inside_res = (w.coord_x >= prof_x[0]) && (w.coord_x <= prof_x[n-1])
                               && (w.coord_y <= h);
            end
            phlc_pkg::CMD_CROSS:
            begin
                if (line_crossing(w.slope, w.coord_x, w.coord_y, w.direction, n, xr))
                begin
                    o.cross_x = xr;
                    o.found = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    // ------------------------------------------------------------------
    // result side: random stalls, compare against the oldest answer
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (rx_stall > 0)
        begin
            out_if.ready <= 1'b0;
            rx_stall = rx_stall - 1;
        end
        else
            out_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        phlc_pkg::out_word_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            n_words_out++;
            // switch between stretches with and without stalls now and then
            if ($urandom_range(0, 39) == 0)
                rx_burst = !rx_burst;
            rx_stall = rx_burst ? 0 : $urandom_range(0, 18);
            if (answer_q.size() == 0)
            begin
                errors++;
                $display("%0t: result word with nothing expected: %p", $time, out_if.payload);
            end
            else
            begin
                want = answer_q.pop_front();
                if (out_if.payload.height !== want.height)
                begin
                    errors++;
                    $display("%0t: height expected %h actual %h", $time,
                             want.height, out_if.payload.height);
                end
                if (out_if.payload.inside_res !== want.inside_res)
                begin
                    errors++;
                    $display("%0t: inside_res expected %b actual %b", $time,
                             want.inside_res, out_if.payload.inside_res);
                end
                if (out_if.payload.cross_x !== want.cross_x)
                begin
                    errors++;
                    $display("%0t: cross_x expected %h actual %h", $time,
                             want.cross_x, out_if.payload.cross_x);
                end
                if (out_if.payload.found !== want.found)
                begin
                    errors++;
                    $display("%0t: found expected %b actual %b", $time,
                             want.found, out_if.payload.found);
                end
            end
        end
    end

    // watchdog: too long without any word moving on either channel
    always @(posedge clk)
    begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_MAX)
        begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_MAX);
            $display("** profile_height_and_line_crossing_core: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // present one word after a random gap; returns at the accepting edge
    task automatic send_word(phlc_pkg::in_word_t w, bit typed, phlc_pkg::out_word_t ans);
        int                  gap;
        phlc_pkg::out_word_t pred;
        @(negedge clk);
        if ($urandom_range(0, 29) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= w;
        do
            @(posedge clk);
        while (!in_if.ready);
        pred = profile_answer(w);
        answer_q.push_back(typed ? ans : pred);
        case (w.cmd)
            phlc_pkg::CMD_WRITE:  n_writes++;
            phlc_pkg::CMD_HEIGHT: n_height++;
            phlc_pkg::CMD_CROSS:  n_cross++;
            default:              n_unused++;
        endcase
        if (pred.found)
            n_found++;
    endtask

    task automatic send_checked(phlc_pkg::in_word_t w);
        send_word(w, 1'b0, '0);
    endtask

    // drop valid and wait for every owed answer, then let the block settle
    task automatic drain();
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (answer_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == phlc_pkg::REG_POINT_COUNT)
            pc_shadow = data[8:0];
    endtask

    task automatic reg_check(logic [2:0] addr, logic [31:0] want);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[8:0] !== want[8:0])
        begin
            errors++;
            $display("%0t: register %0d expected %h actual %h", $time, addr, want, prdata);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic phlc_pkg::in_word_t make_word(logic [1:0] cmd, logic [7:0] idx,
                                                     logic [31:0] x, logic [31:0] y,
                                                     logic [31:0] k, bit dir);
        phlc_pkg::in_word_t w;
        w.cmd       = cmd;
        w.index     = idx;
        w.coord_x   = x;
        w.coord_y   = y;
        w.slope     = k;
        w.direction = dir;
        return w;
    endfunction

    function automatic logic [31:0] near(logic [31:0] v, int span);
        return v + $urandom_range(0, 2 * span) - span;
    endfunction

    // load breakpoints 0..n-1 in one of several shapes
    task automatic load_profile(int n);
        int          xs [$];
        int          shape;
        logic [31:0] base;
        logic [31:0] y;
        int          step;
        shape = $urandom_range(0, 3);
        base  = $urandom();
        for (int i = 0; i < n; i++)
        begin
            case (shape)
                0:
                    xs.push_back(int'($urandom()));
                1:
                begin
                    xs.push_back(int'(base));
                    base += $urandom_range(1, 32'h40000);
                end
                default:
                begin
                    // mostly rising, with flat and backward steps now and then
                    xs.push_back(int'(base));
                    step = $urandom_range(0, 9);
                    if (step == 0)
                        base = base;
                    else if (step == 1)
                        base -= $urandom_range(1, 32'h8000);
                    else
                        base += $urandom_range(1, 32'h30000);
                end
            endcase
        end
        if (shape == 0)
            xs.sort();
        y = $urandom();
        for (int i = 0; i < n; i++)
        begin
            if (shape == 0)
                y = $urandom();
            else
                y = near(y, 32'h30000);
            send_checked(make_word(phlc_pkg::CMD_WRITE, i[7:0], xs[i], y, $urandom(),
                                   1'($urandom_range(0, 1))));
        end
    endtask

    // random mix of queries against the loaded profile
    task automatic query_mix(int count, bit pause_mid);
        int          n;
        int          pick;
        int          j;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] k;
        n = active_points();
        for (int i = 0; i < count; i++)
        begin
            if (pause_mid && i == count / 2)
                drain();
            pick = $urandom_range(0, 99);
            j = $urandom_range(0, n - 1);
            x = ($urandom_range(0, 7) == 0) ? $urandom() : near(prof_x[j], 32'h30000);
            y = ($urandom_range(0, 7) == 0) ? $urandom() : near(prof_y[j], 32'h30000);
            k = ($urandom_range(0, 5) == 0) ? $urandom() : near(32'h0, 32'h40000);
            if (pick < 6)
                send_checked(make_word(phlc_pkg::CMD_WRITE, 8'($urandom()), $urandom(),
                                       $urandom(), $urandom(), 1'($urandom_range(0, 1))));
            else if (pick < 10)
                send_checked(make_word(phlc_pkg::OP_NONE, 8'($urandom()), $urandom(),
                                       $urandom(), $urandom(), 1'($urandom_range(0, 1))));
            else if (pick < 50)
                send_checked(make_word(phlc_pkg::CMD_HEIGHT, 8'($urandom()), x, y, $urandom(),
                                       1'($urandom_range(0, 1))));
            else
                send_checked(make_word(phlc_pkg::CMD_CROSS, 8'($urandom()), x, y, k,
                                       1'($urandom_range(0, 1))));
        end
    endtask

    // new point count while idle, optional reload, then queries
    task automatic run_setting(logic [31:0] pc, int count, bit reload, bit pause_mid);
        drain();
        reg_write(phlc_pkg::REG_POINT_COUNT, pc);
        reg_check(phlc_pkg::REG_POINT_COUNT, pc);
        if (reload)
            load_profile(active_points());
        query_mix(count, pause_mid);
    endtask

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------

    dir_row_t dir_tab [$];

    task automatic add_row(logic [1:0] cmd, logic [7:0] idx, logic [31:0] x, logic [31:0] y,
                           logic [31:0] k, bit dir, bit typed, phlc_pkg::out_word_t ans);
        dir_row_t r;
        r.w     = make_word(cmd, idx, x, y, k, dir);
        r.typed = typed;
        r.ans   = ans;
        dir_tab.push_back(r);
    endtask

    function automatic phlc_pkg::out_word_t ans_of(logic [31:0] h, bit ins, logic [31:0] cx,
                                                   bit f);
        phlc_pkg::out_word_t o;
        o.height     = h;
        o.inside_res = ins;
        o.cross_x    = cx;
        o.found      = f;
        return o;
    endfunction

    task automatic build_table();
        phlc_pkg::out_word_t z;
        z = '0;
        // two-point profile from (0,0) to (1,1)
        add_row(phlc_pkg::CMD_WRITE,  8'd0,  32'h0,        32'h0,        32'h0,        0, 1, z);
        add_row(phlc_pkg::CMD_WRITE,  8'd1,  32'h10000,    32'h10000,    32'hffffffff, 1, 1, z);
        // midpoint, and extrapolation to both extremes of x
        add_row(phlc_pkg::CMD_HEIGHT, 8'd0,  32'h8000,     32'h0,        32'h0,        0, 1,
                ans_of(32'h8000, 1, 0, 0));
        add_row(phlc_pkg::CMD_HEIGHT, 8'hff, 32'h7fffffff, 32'h80000000, 32'h0,        1, 1,
                ans_of(32'h7fffffff, 0, 0, 0));
        add_row(phlc_pkg::CMD_HEIGHT, 8'd0,  32'h80000000, 32'h80000000, 32'h0,        0, 1,
                ans_of(32'h80000000, 0, 0, 0));
        add_row(phlc_pkg::CMD_HEIGHT, 8'd0,  32'h10000,    32'h10000,    32'h0,        0, 0, z);
        // flat line at 0.5 crosses halfway
        add_row(phlc_pkg::CMD_CROSS,  8'd0,  32'h0,        32'h8000,     32'h0,        1, 1,
                ans_of(0, 0, 32'h8000, 1));
        // origin at the first breakpoint, walking left
        add_row(phlc_pkg::CMD_CROSS,  8'd0,  32'h0,        32'h8000,     32'h0,        0, 1, z);
        // parallel line never crosses
        add_row(phlc_pkg::CMD_CROSS,  8'd0,  32'h0,        32'h8000,     32'h10000,    1, 1, z);
        // crossing exactly on a breakpoint is skipped
        add_row(phlc_pkg::CMD_CROSS,  8'd0,  32'hffffffff, 32'h0,        32'h0,        1, 1, z);
        add_row(phlc_pkg::CMD_CROSS,  8'd0,  32'h8000,     32'h10000,    32'h0,        1, 1, z);
        // origin right of the profile: rightward finds nothing, leftward walks back
        add_row(phlc_pkg::CMD_CROSS,  8'd0,  32'h20000,    32'h8000,     32'h0,        1, 1, z);
        add_row(phlc_pkg::CMD_CROSS,  8'd0,  32'h20000,    32'h8000,     32'h0,        0, 0, z);
        // steep slopes at both extremes
        add_row(phlc_pkg::CMD_CROSS,  8'd0,  32'h80000000, 32'h7fffffff, 32'h80000000, 1, 0, z);
        add_row(phlc_pkg::CMD_CROSS,  8'd0,  32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, z);
        // unused command answers all zero
        add_row(phlc_pkg::OP_NONE,    8'hff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1, 1, z);
        // top index, extreme coordinates
        add_row(phlc_pkg::CMD_WRITE,  8'hff, 32'h7fffffff, 32'h80000000, 32'h0,        1, 1, z);
        // zero-width segment gives the left height
        add_row(phlc_pkg::CMD_WRITE,  8'd1,  32'h0,        32'h50000,    32'h0,        0, 1, z);
        add_row(phlc_pkg::CMD_HEIGHT, 8'd0,  32'h123,      32'h0,        32'h0,        0, 1, z);
        add_row(phlc_pkg::CMD_CROSS,  8'd0,  32'hffff0000, 32'h8000,     32'h0,        1, 1, z);
        add_row(phlc_pkg::CMD_WRITE,  8'd1,  32'h10000,    32'h10000,    32'h0,        0, 1, z);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        out_if.ready  = 1'b0;
        errors        = 0;
        idle_cycles   = 0;
        rx_stall      = 0;
        rx_burst      = 1'b0;
        tx_burst      = 1'b0;
        n_writes      = 0;
        n_height      = 0;
        n_cross       = 0;
        n_found       = 0;
        n_unused      = 0;
        n_words_out   = 0;
        pc_shadow     = 9'd2;
        for (int i = 0; i < NPTS; i++)
        begin
            prof_x[i] = '0;
            prof_y[i] = '0;
            loaded[i] = 1'b0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // point count comes out of reset at two
        reg_check(phlc_pkg::REG_POINT_COUNT, 32'd2);
        build_table();
        foreach (dir_tab[i])
            send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].ans);

        // several settings: small counts, out-of-range values, the maximum
        run_setting(32'd2,   30, 1'b1, 1'b0);
        run_setting(32'd3,   30, 1'b1, 1'b1);
        run_setting(32'd7,   30, 1'b1, 1'b0);
        run_setting(32'd16,  30, 1'b1, 1'b0);
        run_setting(32'd0,   20, 1'b0, 1'b0);
        run_setting(32'd1,   20, 1'b1, 1'b0);
        run_setting(32'd511, 4,  1'b1, 1'b0);
        run_setting(32'd256, 3,  1'b0, 1'b0);
        run_setting(32'd5,   30, 1'b1, 1'b0);
        run_setting(32'd2,   25, 1'b1, 1'b0);

        drain();
        repeat (DRAIN_CYC) @(posedge clk);
        if (answer_q.size() != 0)
        begin
            errors++;
            $display("%0t: %0d answers never arrived", $time, answer_q.size());
        end

        $display("run covered %0d breakpoint writes, %0d height and %0d crossing queries",
                 n_writes, n_height, n_cross);
        $display("%0d crossings found, %0d unused-command words, %0d result words checked",
                 n_found, n_unused, n_words_out);
        if (errors == 0)
            $display("** profile_height_and_line_crossing_core: PASSED **");
        else
            $display("** profile_height_and_line_crossing_core: FAILED **");
        $finish;
    end

endmodule
